// ===== rtl/core/three_axis_moving_average_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis moving-average core
// Shared property wrappers with a common clock, reset and report.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_MOVING_AVERAGE_CORE_ASSERT_SVH
`define THREE_AXIS_MOVING_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TAMA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("moving average core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TAMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("moving average core: next-cycle check failed");

`endif

// ===== rtl/core/tama_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tama_pkg
// Shared types and constants of the three-axis moving-average core.
// ----------------------------------------------------------------------------
package tama_pkg;

   localparam int unsigned DATA_W         = 16;
   localparam int unsigned AXES           = 3;
   localparam int unsigned DEFAULT_WINDOW = 8;

   // One sample or one mean: a value per axis.
   typedef struct packed {
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] z;
   } axes_type;

   // Pipeline control from the top level to the history and accumulator.
   typedef struct packed {
      logic accept;   // input transfer this cycle
      logic update;   // first stage moves into the accumulator
   } ctrl_type;

endpackage

// ===== rtl/core/tama_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tama_req_if
// Sample channel: valid/ready handshake carrying one three-axis sample.
// ----------------------------------------------------------------------------
interface tama_req_if
   import tama_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sample_x;
   logic [DATA_W-1:0] sample_y;
   logic [DATA_W-1:0] sample_z;

   modport source (output valid, output sample_x, output sample_y, output sample_z,
                   input ready);
   modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                   output ready);
endinterface

// ===== rtl/core/tama_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tama_rsp_if
// Result channel: valid/ready handshake carrying one three-axis mean.
// ----------------------------------------------------------------------------
interface tama_rsp_if
   import tama_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] mean_x;
   logic [DATA_W-1:0] mean_y;
   logic [DATA_W-1:0] mean_z;

   modport source (output valid, output mean_x, output mean_y, output mean_z,
                   input ready);
   modport sink   (input valid, input mean_x, input mean_y, input mean_z,
                   output ready);
endinterface

// ===== rtl/core/tama_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tama_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tama_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read and write to one address return the old word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tama_hist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tama_hist
// Sample history as a circular buffer in RAM; returns the sample leaving
// the window in the cycle after the transfer that replaces it.
// ----------------------------------------------------------------------------
module tama_hist
   import tama_pkg::*;
#(
   parameter int unsigned WINDOW = DEFAULT_WINDOW
) (
   input  logic     clock,
   input  logic     reset,
   input  ctrl_type ctrl,
   input  axes_type fresh,
   output axes_type oldest
);

   localparam int unsigned PTR_W = $clog2(WINDOW);
   localparam int unsigned WORD_W = AXES * DATA_W;

   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic              wrapped_ff, wrapped_in;
   logic              empty_ff, empty_in;
   logic [WORD_W-1:0] rd_word;

   // Read the outgoing entry and overwrite it with the new sample.
   tama_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.accept),
      .wr_addr (ptr_ff),
      .wr_data (fresh),
      .rd_en   (ctrl.accept),
      .rd_addr (ptr_ff),
      .rd_data (rd_word)
   );

   always_comb begin
      ptr_in     = ptr_ff;
      wrapped_in = wrapped_ff;
      empty_in   = empty_ff;
      if (ctrl.accept) begin
         // Entries not yet written on the first lap read as zero.
         empty_in = !wrapped_ff;
         if (ptr_ff == PTR_W'(WINDOW - 1)) begin
            ptr_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         wrapped_ff <= 1'b0;
         empty_ff   <= 1'b1;
      end else begin
         ptr_ff     <= ptr_in;
         wrapped_ff <= wrapped_in;
         empty_ff   <= empty_in;
      end
   end

   assign oldest = empty_ff ? '0 : axes_type'(rd_word);

endmodule

// ===== rtl/core/tama_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tama_accum
// Running window sums per axis and the mean by reciprocal multiplication.
// ----------------------------------------------------------------------------
module tama_accum
   import tama_pkg::*;
#(
   parameter int unsigned WINDOW = DEFAULT_WINDOW
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ctrl_type                             ctrl,
   input  axes_type                             fresh,
   input  axes_type                             oldest,
   output logic [AXES-1:0][DATA_W+$clog2(WINDOW)-1:0] sum,
   output axes_type                             mean
);

   localparam int unsigned LOG_W   = $clog2(WINDOW);
   localparam int unsigned SUM_W   = DATA_W + LOG_W;
   localparam int unsigned SHIFT   = SUM_W + LOG_W;
   localparam int unsigned RECIP_W = SUM_W + 1;
   localparam int unsigned PROD_W  = SUM_W + RECIP_W;
   // ceil(2^SHIFT / WINDOW): exact floor division for any SUM_W-bit sum.
   localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;

   logic [AXES-1:0][SUM_W-1:0]  sum_ff, sum_in;
   logic [AXES-1:0][DATA_W-1:0] add_v, sub_v, quot;
   logic [AXES-1:0][PROD_W-1:0] prod;
   logic [RECIP_W-1:0]          recip_c;

   assign add_v   = {fresh.x, fresh.y, fresh.z};
   assign sub_v   = {oldest.x, oldest.y, oldest.z};
   assign recip_c = RECIP_W'(RECIP);

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         sum_in[a] = sum_ff[a];
         if (ctrl.update) begin
            sum_in[a] = sum_ff[a] + SUM_W'(add_v[a]) - SUM_W'(sub_v[a]);
         end
         prod[a] = {{RECIP_W{1'b0}}, sum_ff[a]} * {{SUM_W{1'b0}}, recip_c};
         quot[a] = prod[a][SHIFT +: DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum  = sum_ff;
   assign mean = '{x: quot[2], y: quot[1], z: quot[0]};

endmodule

// ===== rtl/core/three_axis_moving_average_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_moving_average_core
// Boxcar moving average over the last WINDOW samples of three axes.
// ----------------------------------------------------------------------------
// One result per sample: for each axis the sum of the last WINDOW samples,
// divided by WINDOW and truncated; the windows start as zeros, so early
// results average against zeros. The core takes one sample every cycle
// while no stage is stalled by the result port, and passes it through
// registers in order: the history RAM registers the sample leaving the
// window at the transfer edge itself, the running sums update, and the
// reciprocal multiply then loads the output register, which holds the mean
// on the result port until the receiver is ready. The history lives in a
// WINDOW-entry RAM used as a circular buffer; no clearing pass is needed
// after reset, because a first-lap flag makes entries not yet written read
// as zero. The sums carry 16 + ceil(log2(WINDOW)) bits and never wrap.
// ----------------------------------------------------------------------------
`include "three_axis_moving_average_core_assert.svh"

module three_axis_moving_average_core
   import tama_pkg::*;
#(
   parameter int unsigned WINDOW = DEFAULT_WINDOW
) (
   input  logic       clock,
   input  logic       reset,
   tama_req_if.sink   req_port,
   tama_rsp_if.source rsp_port
);

   localparam int unsigned SUM_W = DATA_W + $clog2(WINDOW);

   // Stage flags: s1 = RAM read in flight, s2 = sum updated, out = result held.
   logic     s1_valid_ff, s1_valid_in;
   logic     s2_valid_ff, s2_valid_in;
   logic     out_valid_ff, out_valid_in;
   axes_type s1_fresh_ff;
   axes_type mean_ff;

   logic     adv_out, adv_s2, adv_s1;
   logic     accept;
   ctrl_type ctrl;
   axes_type fresh, oldest, mean;
   logic [AXES-1:0][SUM_W-1:0] sum;

   // Each stage advances when the one after it is empty or moving on,
   // so bubbles collapse and the input keeps taking transfers while the stages can move.
   assign adv_out = !out_valid_ff || rsp_port.ready;
   assign adv_s2  = !s2_valid_ff || adv_out;
   assign adv_s1  = !s1_valid_ff || adv_s2;

   assign req_port.ready = adv_s1;
   assign accept         = req_port.valid && adv_s1;

   assign fresh = '{x: req_port.sample_x, y: req_port.sample_y, z: req_port.sample_z};

   assign ctrl = '{accept: accept, update: s1_valid_ff && adv_s2};

   // History RAM: read outgoing sample, write the new one.
   tama_hist #(
      .WINDOW (WINDOW)
   ) u_hist (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .fresh  (fresh),
      .oldest (oldest)
   );

   // Running sums and mean.
   tama_accum #(
      .WINDOW (WINDOW)
   ) u_accum (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .fresh  (s1_fresh_ff),
      .oldest (oldest),
      .sum    (sum),
      .mean   (mean)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s2_valid_in  = s2_valid_ff;
      out_valid_in = out_valid_ff;
      if (adv_s1) begin
         s1_valid_in = accept;
      end
      if (adv_s2) begin
         s2_valid_in = s1_valid_ff;
      end
      if (adv_out) begin
         out_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: hold the sample beside its RAM read; load the mean on advance.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_fresh_ff <= fresh;
      end
      if (adv_out && s2_valid_ff) begin
         mean_ff <= mean;
      end
   end

   assign rsp_port.valid  = out_valid_ff;
   assign rsp_port.mean_x = mean_ff.x;
   assign rsp_port.mean_y = mean_ff.y;
   assign rsp_port.mean_z = mean_ff.z;

   // An accepted sample occupies the first stage on the next cycle.
   `TAMA_ASSERT_NEXT(a_accept_fills_s1, clock, reset, accept, s1_valid_ff)
   // A stalled first stage keeps its item.
   `TAMA_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !adv_s2, s1_valid_ff)
   // The running sums do not move while the sum stage is blocked.
   `TAMA_ASSERT_NEXT(a_sum_holds, clock, reset, !adv_s2, $stable(sum))

endmodule
